>>> rtl/ddfrs_pkg.sv
package ddfrs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int NQ        = 4;
  localparam int NOW_W     = 32;
  localparam int EXP_W     = 16;
  localparam int LIM_W     = 8;
  localparam int OUT_TAG_W = 16;
  localparam int PROD_W    = EXP_W + LIM_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    CL_SR = 2'd0,
    CL_SW = 2'd1,
    CL_AR = 2'd2,
    CL_AW = 2'd3
  } qcls_t;

  typedef enum logic {
    OP_ENQ  = 1'b0,
    OP_DISP = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_SR_EXPIRE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SW_EXPIRE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AR_EXPIRE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AW_EXPIRE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MUL = 3'd5;

  localparam logic [EXP_W-1:0] RST_SR_EXPIRE = 16'd25;
  localparam logic [EXP_W-1:0] RST_SW_EXPIRE = 16'd500;
  localparam logic [EXP_W-1:0] RST_AR_EXPIRE = 16'd100;
  localparam logic [EXP_W-1:0] RST_AW_EXPIRE = 16'd600;
  localparam logic [LIM_W-1:0] RST_BATCH_LIM = 8'd2;
  localparam logic [LIM_W-1:0] RST_SLEEP_MUL = 8'd50;
  localparam logic [LIM_W-1:0] BATCH_MAX     = 8'd255;

  localparam qcls_t ORDER_ON  [NQ] = '{CL_SR, CL_AR, CL_SW, CL_AW};
  localparam qcls_t ORDER_OFF [NQ] = '{CL_AR, CL_SR, CL_AW, CL_SW};

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic                 accepted;
    logic                 dispatched;
    logic [OUT_TAG_W-1:0] tag;
    logic                 sync;
    logic                 write;
    logic                 expired;
  } rsp_t;

endpackage

>>> rtl/ddfrs_if.sv
interface ddfrs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now;
  logic        display_on;
  logic        is_sync;
  logic        is_write;
  logic [15:0] request_tag;

  modport source (output valid, opcode, now, display_on, is_sync, is_write, request_tag,
                  input ready);
  modport sink (input valid, opcode, now, display_on, is_sync, is_write, request_tag,
                output ready);
endinterface

interface ddfrs_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        dispatched;
  logic [15:0] out_tag;
  logic        out_sync;
  logic        out_write;
  logic        out_expired;

  modport source (output valid, accepted, dispatched, out_tag, out_sync, out_write,
                  out_expired, input ready);
  modport sink (input valid, accepted, dispatched, out_tag, out_sync, out_write,
                out_expired, output ready);
endinterface

interface ddfrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ddfrs_queue.sv
module ddfrs_queue
  import ddfrs_pkg::*;
#(
  parameter int DEPTH    = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qctl_t               ctl,
  input  logic [TAG_BITS-1:0] push_tag,
  input  logic [NOW_W-1:0]    push_deadline,
  output qstat_t              stat,
  output logic [TAG_BITS-1:0] head_tag,
  output logic [NOW_W-1:0]    head_deadline
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = TAG_BITS + NOW_W;

  logic [ENT_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ENT_W-1:0] rd_r;
  logic [ENT_W-1:0] wdata, wdata_r;
  logic             byp_r;
  logic [ENT_W-1:0] head_ent;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wdata = {push_tag, push_deadline};

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.push) begin
      tail_nxt = next_slot(tail_r);
      cnt_nxt  = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      head_nxt = next_slot(head_r);
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      byp_r  <= ctl.push && (tail_r == head_nxt);
    end
  end

  // next head is prefetched; a write to that slot in the same cycle is bypassed
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wdata;
    end
    rd_r    <= mem[head_nxt];
    wdata_r <= wdata;
  end

  assign head_ent      = byp_r ? wdata_r : rd_r;
  assign head_tag      = head_ent[ENT_W-1:NOW_W];
  assign head_deadline = head_ent[NOW_W-1:0];
  assign stat.empty    = (cnt_r == '0);
  assign stat.full     = (cnt_r == CNT_W'(DEPTH));

endmodule

>>> rtl/deadline_dual_fifo_request_scheduler_core.sv
// Deadline request scheduler with four request FIFOs (sync read, sync write, async read,
// async write). An enqueue request stamps its deadline as now plus the class expiry (times
// sleep_multiple while the display is off) and is rejected on a zero expiry or a full FIFO.
// A dispatch request, with the display on and the batch count at or above its limit,
// first takes the first expired head in sync read, async read, sync write, async write
// order; otherwise it takes a head by the display-dependent priority order.
// Every request returns exactly one result, in the cycle after it is taken. The block takes
// one request per clock; in_req.ready drops only while a result waits on out_rsp. Each FIFO
// keeps its head in a register prefetched from its entry memory at the same edge that pushes
// or pops, so head compare, pick and pointer update all finish in the request's own cycle.
module deadline_dual_fifo_request_scheduler_core
  import ddfrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ddfrs_in_if.sink    in_req,
  ddfrs_out_if.source out_rsp,
  ddfrs_cfg_if.sink   cfg_wr
);

  logic [EXP_W-1:0]  expire_r [NQ];
  logic [LIM_W-1:0]  limit_r;
  logic [LIM_W-1:0]  sleep_r;
  logic [LIM_W-1:0]  batch_r, batch_nxt;
  logic              out_valid_r;
  rsp_t              rsp_r, rsp_nxt;

  qctl_t             q_ctl  [NQ];
  qstat_t            q_stat [NQ];
  logic [TAG_BITS-1:0] q_tag [NQ];
  logic [NOW_W-1:0]  q_dl   [NQ];
  logic [NQ-1:0]     q_exp;

  logic              acc;
  qcls_t             cls;
  logic [EXP_W-1:0]  exp_sel;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] eff;
  logic [NOW_W-1:0]  deadline;
  logic [TAG_BITS-1:0] wtag;
  logic              enq_ok;
  logic              chk;

  assign acc          = in_req.valid && in_req.ready;
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign cfg_wr.ready = 1'b1;

  assign cls      = qcls_t'({~in_req.is_sync, in_req.is_write});
  assign exp_sel  = expire_r[cls];
  assign prod     = PROD_W'(exp_sel) * PROD_W'(sleep_r);
  assign eff      = in_req.display_on ? PROD_W'(exp_sel) : prod;
  assign deadline = in_req.now + NOW_W'(eff);
  assign wtag     = TAG_BITS'(in_req.request_tag);
  assign enq_ok   = (eff != '0) && !q_stat[cls].full;
  assign chk      = in_req.display_on && (batch_r >= limit_r);

  for (genvar q = 0; q < NQ; q++) begin : g_q
    logic [NOW_W-1:0] diff;

    ddfrs_queue #(
      .DEPTH    (QUEUE_DEPTH),
      .TAG_BITS (TAG_BITS)
    ) u_queue (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (q_ctl[q]),
      .push_tag      (wtag),
      .push_deadline (deadline),
      .stat          (q_stat[q]),
      .head_tag      (q_tag[q]),
      .head_deadline (q_dl[q])
    );

    assign diff     = in_req.now - q_dl[q];
    assign q_exp[q] = !q_stat[q].empty && (diff != '0) && !diff[NOW_W-1];
  end

  always_comb begin
    logic             found;
    qcls_t            sel;
    logic [LIM_W-1:0] base;

    found     = 1'b0;
    sel       = CL_SR;
    base      = batch_r;
    rsp_nxt   = '0;
    batch_nxt = batch_r;
    for (int q = 0; q < NQ; q++) begin
      q_ctl[q] = '0;
    end

    if (in_req.opcode == OP_ENQ) begin
      if (enq_ok) begin
        q_ctl[cls].push  = acc;
        rsp_nxt.accepted = 1'b1;
      end
    end else begin
      if (chk) begin
        base = '0;
        for (int i = 0; i < NQ; i++) begin
          if (!found && q_exp[ORDER_ON[i]]) begin
            found           = 1'b1;
            sel             = ORDER_ON[i];
            rsp_nxt.expired = 1'b1;
          end
        end
      end
      batch_nxt = base;
      if (!found) begin
        batch_nxt = (base == BATCH_MAX) ? base : base + 1'b1;
        for (int i = 0; i < NQ; i++) begin
          if (in_req.display_on) begin
            if (!found && !q_stat[ORDER_ON[i]].empty) begin
              found = 1'b1;
              sel   = ORDER_ON[i];
            end
          end else begin
            if (!found && !q_stat[ORDER_OFF[i]].empty) begin
              found = 1'b1;
              sel   = ORDER_OFF[i];
            end
          end
        end
      end
      if (found) begin
        q_ctl[sel].pop     = acc;
        rsp_nxt.dispatched = 1'b1;
        rsp_nxt.tag        = OUT_TAG_W'(q_tag[sel]);
        rsp_nxt.sync       = (sel == CL_SR) || (sel == CL_SW);
        rsp_nxt.write      = (sel == CL_SW) || (sel == CL_AW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expire_r[CL_SR] <= RST_SR_EXPIRE;
      expire_r[CL_SW] <= RST_SW_EXPIRE;
      expire_r[CL_AR] <= RST_AR_EXPIRE;
      expire_r[CL_AW] <= RST_AW_EXPIRE;
      limit_r         <= RST_BATCH_LIM;
      sleep_r         <= RST_SLEEP_MUL;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_SR_EXPIRE: expire_r[CL_SR] <= cfg_wr.data;
        REG_SW_EXPIRE: expire_r[CL_SW] <= cfg_wr.data;
        REG_AR_EXPIRE: expire_r[CL_AR] <= cfg_wr.data;
        REG_AW_EXPIRE: expire_r[CL_AW] <= cfg_wr.data;
        REG_BATCH_LIM: limit_r         <= cfg_wr.data[LIM_W-1:0];
        REG_SLEEP_MUL: sleep_r         <= cfg_wr.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        batch_r     <= batch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.accepted    = rsp_r.accepted;
  assign out_rsp.dispatched  = rsp_r.dispatched;
  assign out_rsp.out_tag     = rsp_r.tag;
  assign out_rsp.out_sync    = rsp_r.sync;
  assign out_rsp.out_write   = rsp_r.write;
  assign out_rsp.out_expired = rsp_r.expired;

endmodule

>>> rtl/ddfrs_checker.sv
module ddfrs_checker
  import ddfrs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_dispatched,
  input logic [15:0] out_tag,
  input logic        out_expired
);

  a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("request taken without a result the next cycle");

  a_enq_no_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_ENQ) |=>
      !out_dispatched && !out_expired && (out_tag == '0))
    else $error("enqueue result shows dispatch fields");

  a_disp_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_DISP) |=> !out_accepted)
    else $error("dispatch result shows accepted");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_dispatched))
    else $error("stalled result changed");

endmodule

bind deadline_dual_fifo_request_scheduler_core ddfrs_checker u_ddfrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .in_opcode      (in_req.opcode),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_accepted   (out_rsp.accepted),
  .out_dispatched (out_rsp.dispatched),
  .out_tag        (out_rsp.out_tag),
  .out_expired    (out_rsp.out_expired)
);
